// ===== design/matrix_inverse_4x4_top_assert.svh =====
// assertion macros for the matrix inverse top level
// no dependencies
`ifndef MATRIX_INVERSE_4X4_TOP_ASSERT_SVH
`define MATRIX_INVERSE_4X4_TOP_ASSERT_SVH
`define MI_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define MI_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

// ===== design/mi4_pkg.sv =====
// types and constants shared by the matrix inverse modules
// no dependencies
package mi4_pkg;
   typedef logic signed [31:0] elem_type;
   localparam logic [1:0] OP_MUL = 2'd0;
   localparam logic [1:0] OP_SUB = 2'd1;
   localparam logic [1:0] OP_PASS = 2'd2;
   typedef struct packed {
      logic       start;
      logic [1:0] op;
   } alu_ctl_type;
endpackage

// ===== design/mi4_alu.sv =====
// shared multiply / subtract / pass unit with saturation, one registered stage
// depends on mi4_pkg
module mi4_alu #(
   parameter int FRAC_BITS = 16
) (
   input  logic                clock,
   input  mi4_pkg::alu_ctl_type ctl,
   input  mi4_pkg::elem_type   a,
   input  mi4_pkg::elem_type   b,
   input  mi4_pkg::elem_type   x,
   output mi4_pkg::elem_type   res_ff,
   output logic                sat_ff
);
   logic signed [63:0] prod;
   logic signed [64:0] rnd;
   logic signed [64:0] val;
   logic signed [64:0] lim_hi;
   logic signed [64:0] lim_lo;
   mi4_pkg::elem_type  res_in;
   logic               sat_in;

   always_comb begin
      prod   = 64'(a) * 64'(b);
      rnd    = (65'(prod) + (65'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
      lim_hi = 65'sd2147483647;
      lim_lo = -65'sd2147483648;
      case (ctl.op)
         mi4_pkg::OP_MUL:  val = rnd;
         mi4_pkg::OP_SUB:  val = 65'(x) - rnd;
         default:          val = 65'(x);
      endcase
      sat_in = 1'b0;
      res_in = val[31:0];
      if (val > lim_hi) begin
         res_in = 32'sh7fffffff;
         sat_in = ctl.start;
      end else if (val < lim_lo) begin
         res_in = 32'sh80000000;
         sat_in = ctl.start;
      end
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
      sat_ff <= sat_in;
   end
endmodule

// ===== design/mi4_recip.sv =====
// bit-serial reciprocal: round(2^(2F) / m), signed, saturated
// depends on mi4_pkg
module mi4_recip #(
   parameter int FRAC_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  mi4_pkg::elem_type pivot,
   output logic              done,
   output mi4_pkg::elem_type recip,
   output logic              sat
);
   localparam int NB = 2 * FRAC_BITS + 2;
   logic [NB-1:0] num_ff, num_in;
   logic [32:0]   rem_ff, rem_in;
   logic [32:0]   den_ff, den_in;
   logic [NB-1:0] quo_ff, quo_in;
   logic [6:0]    cnt_ff, cnt_in;
   logic          busy_ff, busy_in, neg_ff, neg_in, done_in, done_ff;
   logic [33:0]   trial;
   logic [31:0]   mag;

   assign mag = pivot[31] ? 32'(-pivot) : 32'(pivot);
   assign trial = {rem_ff, num_ff[NB-1]} - {1'b0, den_ff};

   always_comb begin
      num_in = num_ff; rem_in = rem_ff; den_in = den_ff; quo_in = quo_ff;
      cnt_in = cnt_ff; busy_in = busy_ff; neg_in = neg_ff; done_in = 1'b0;
      if (start) begin
         num_in  = (NB'(1) << (2 * FRAC_BITS)) + NB'(mag >> 1);
         den_in  = {1'b0, mag};
         rem_in  = '0; quo_in = '0; cnt_in = 7'(NB);
         busy_in = 1'b1; neg_in = pivot[31];
      end else if (busy_ff) begin
         num_in = num_ff << 1;
         if (!trial[33]) begin
            rem_in = trial[32:0];
            quo_in = {quo_ff[NB-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[31:0], num_ff[NB-1]};
            quo_in = {quo_ff[NB-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0; cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in; cnt_ff <= cnt_in;
      end
      num_ff <= num_in; rem_ff <= rem_in; den_ff <= den_in;
      quo_ff <= quo_in; neg_ff <= neg_in;
   end

   always_comb begin
      done = done_ff;
      sat  = 1'b0;
      if (!neg_ff) begin
         if (quo_ff > NB'(32'h7fffffff)) begin
            recip = 32'sh7fffffff; sat = 1'b1;
         end else recip = quo_ff[31:0];
      end else begin
         if (quo_ff > NB'(33'h80000000)) begin
            recip = 32'sh80000000; sat = 1'b1;
         end else recip = 32'(-quo_ff[31:0]);
      end
   end
endmodule

// ===== design/matrix_inverse_4x4_top.sv =====
// matrix inverse top level: load, gauss-jordan sequencer, output
// depends on mi4_pkg, mi4_alu, mi4_recip, matrix_inverse_4x4_top_assert.svh
//
// usage: send 16 signed Q16.16 elements, row-major, on req_ (valid/ready).
// after the 16th transaction the block drops req_ready and eliminates with
// partial pivoting, column by column, on one shared multiply/subtract unit,
// which registers each element result before it is written back, and on a
// bit-serial divider for the reciprocal pivot.
// the steps are a copy of the matrix into the work stores, then per column
// a search, a swap, the reciprocal, the scaling of the pivot row and the
// elimination of the other rows, and at the end the output fetch.
// results leave as 16 rsp_ transactions, each fetched from the store before
// it is offered, with rsp_last_out on the last; rsp_singular and rsp_overflow
// hold for the matrix.
// a stalled rsp_ready holds the current result; nothing is lost.
// a new matrix is taken once the last result transaction completes.
// csr_pivot_epsilon is to be written with csr_write_enable only while idle;
// the user is bound by this, the block itself does not enforce it.
// reset clears the sequencer and sets the epsilon to 1; the matrix stores
// are not cleared.
module matrix_inverse_4x4_top #(
   parameter int DIM       = 4,
   parameter int FRAC_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic signed [31:0]   req_element_in,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic signed [31:0]   rsp_element_out,
   output logic                 rsp_singular,
   output logic                 rsp_overflow,
   output logic                 rsp_last_out,
   input  logic                 csr_write_enable,
   input  logic [15:0]          csr_pivot_epsilon
);
   `include "matrix_inverse_4x4_top_assert.svh"
   localparam int N  = DIM * DIM;
   localparam int NW = $clog2(N);
   localparam int DW = $clog2(DIM);

   localparam logic [3:0] S_LOAD  = 4'd0;
   localparam logic [3:0] S_INIT  = 4'd1;
   localparam logic [3:0] S_SRCH  = 4'd2;
   localparam logic [3:0] S_SWAP  = 4'd3;
   localparam logic [3:0] S_RSTRT = 4'd4;
   localparam logic [3:0] S_RWAIT = 4'd5;
   localparam logic [3:0] S_SCALE = 4'd6;
   localparam logic [3:0] S_FACT  = 4'd7;
   localparam logic [3:0] S_ELIM  = 4'd8;
   localparam logic [3:0] S_OUT   = 4'd9;

   mi4_pkg::elem_type orig_mem [N];
   mi4_pkg::elem_type work_ff  [N];
   mi4_pkg::elem_type inv_ff   [N];

   logic [3:0]    state_ff;
   logic [NW:0]   cnt_ff;
   logic [DW-1:0] col_ff, row_ff, best_ff, c_ff;
   logic          mat_ff;
   logic          ph_ff;
   logic          sing_ff, ovf_ff;
   logic [15:0]   eps_ff;
   mi4_pkg::elem_type recip_ff, fact_ff, rd_ff;

   mi4_pkg::alu_ctl_type alu_ctl;
   mi4_pkg::elem_type    alu_a, alu_b, alu_x, alu_res;
   logic                 alu_sat, rc_start, rc_done, rc_sat;
   mi4_pkg::elem_type    rc_q;
   logic [NW-1:0]        pidx, tidx;
   logic [31:0]          mag_r, mag_b;

   function automatic logic [31:0] mag(input mi4_pkg::elem_type v);
      mag = v[31] ? 32'(-v) : 32'(v);
   endfunction

   assign req_ready = (state_ff == S_LOAD);
   assign rsp_valid = (state_ff == S_OUT) && ph_ff;
   assign rsp_element_out = rd_ff;
   assign rsp_singular = sing_ff;
   assign rsp_overflow = ovf_ff;
   assign rsp_last_out = (cnt_ff == (NW+1)'(N - 1));

   assign pidx  = NW'(col_ff) * NW'(DIM) + NW'(c_ff);
   assign tidx  = NW'(row_ff) * NW'(DIM) + NW'(c_ff);
   assign mag_r = mag(work_ff[NW'(row_ff) * NW'(DIM) + NW'(col_ff)]);
   assign mag_b = mag(work_ff[NW'(best_ff) * NW'(DIM) + NW'(col_ff)]);

   always_comb begin
      alu_ctl.start = 1'b0;
      alu_ctl.op    = mi4_pkg::OP_PASS;
      alu_a = mat_ff ? inv_ff[pidx] : work_ff[pidx];
      alu_b = recip_ff;
      alu_x = '0;
      if (state_ff == S_SCALE) begin
         alu_ctl.start = !ph_ff;
         alu_ctl.op    = mi4_pkg::OP_MUL;
      end else if (state_ff == S_ELIM) begin
         alu_ctl.start = !ph_ff;
         alu_ctl.op    = mi4_pkg::OP_SUB;
         alu_b = fact_ff;
         alu_x = mat_ff ? inv_ff[tidx] : work_ff[tidx];
      end
   end

   mi4_alu #(.FRAC_BITS(FRAC_BITS)) u_alu (
      .clock(clock), .ctl(alu_ctl), .a(alu_a), .b(alu_b), .x(alu_x),
      .res_ff(alu_res), .sat_ff(alu_sat)
   );

   assign rc_start = (state_ff == S_RSTRT);
   mi4_recip #(.FRAC_BITS(FRAC_BITS)) u_recip (
      .clock(clock), .reset(reset), .start(rc_start),
      .pivot(work_ff[NW'(col_ff) * NW'(DIM) + NW'(col_ff)]),
      .done(rc_done), .recip(rc_q), .sat(rc_sat)
   );

   always_ff @(posedge clock) begin
      if (state_ff == S_LOAD && req_valid)
         orig_mem[cnt_ff[NW-1:0]] <= req_element_in;
      if (state_ff == S_OUT && !ph_ff)
         rd_ff <= sing_ff ? orig_mem[cnt_ff[NW-1:0]] : inv_ff[cnt_ff[NW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD; cnt_ff <= '0; ph_ff <= 1'b0; eps_ff <= 16'd1;
         col_ff <= '0; row_ff <= '0; best_ff <= '0; c_ff <= '0; mat_ff <= 1'b0;
         sing_ff <= 1'b0; ovf_ff <= 1'b0;
      end else begin
         if (csr_write_enable) eps_ff <= csr_pivot_epsilon;
         case (state_ff)
            S_LOAD: if (req_valid) begin
               if (cnt_ff == (NW+1)'(N - 1)) begin
                  cnt_ff <= '0; state_ff <= S_INIT;
                  row_ff <= '0; c_ff <= '0;
                  sing_ff <= 1'b0; ovf_ff <= 1'b0;
               end else cnt_ff <= cnt_ff + 1'b1;
            end
            S_INIT: begin
               work_ff[cnt_ff[NW-1:0]] <= orig_mem[cnt_ff[NW-1:0]];
               inv_ff[cnt_ff[NW-1:0]] <= (row_ff == c_ff) ? 32'(1) << FRAC_BITS : '0;
               if (cnt_ff == (NW+1)'(N - 1)) begin
                  cnt_ff <= '0; col_ff <= '0; row_ff <= '0; best_ff <= '0;
                  c_ff <= '0; state_ff <= S_SRCH;
               end else begin
                  cnt_ff <= cnt_ff + 1'b1;
                  if (c_ff == DW'(DIM - 1)) begin
                     c_ff <= '0; row_ff <= row_ff + 1'b1;
                  end else c_ff <= c_ff + 1'b1;
               end
            end
            S_SRCH: begin
               if (mag_r > mag_b) best_ff <= row_ff;
               if (row_ff == DW'(DIM - 1)) begin
                  row_ff <= '0; state_ff <= S_SWAP;
               end else row_ff <= row_ff + 1'b1;
            end
            S_SWAP: begin
               if (mag_b <= 32'(eps_ff)) begin
                  sing_ff <= 1'b1; cnt_ff <= '0; ph_ff <= 1'b0; state_ff <= S_OUT;
               end else begin
                  if (best_ff != col_ff) begin
                     for (int c = 0; c < DIM; c++) begin
                        work_ff[NW'(col_ff) * NW'(DIM) + NW'(c)] <=
                           work_ff[NW'(best_ff) * NW'(DIM) + NW'(c)];
                        work_ff[NW'(best_ff) * NW'(DIM) + NW'(c)] <=
                           work_ff[NW'(col_ff) * NW'(DIM) + NW'(c)];
                        inv_ff[NW'(col_ff) * NW'(DIM) + NW'(c)] <=
                           inv_ff[NW'(best_ff) * NW'(DIM) + NW'(c)];
                        inv_ff[NW'(best_ff) * NW'(DIM) + NW'(c)] <=
                           inv_ff[NW'(col_ff) * NW'(DIM) + NW'(c)];
                     end
                  end
                  state_ff <= S_RSTRT;
               end
            end
            S_RSTRT: state_ff <= S_RWAIT;
            S_RWAIT: if (rc_done) begin
               recip_ff <= rc_q;
               if (rc_sat) ovf_ff <= 1'b1;
               c_ff <= '0; mat_ff <= 1'b0; ph_ff <= 1'b0; state_ff <= S_SCALE;
            end
            S_SCALE: begin
               ph_ff <= !ph_ff;
               if (ph_ff) begin
                  if (mat_ff) inv_ff[pidx] <= alu_res; else work_ff[pidx] <= alu_res;
                  if (alu_sat) ovf_ff <= 1'b1;
                  if (c_ff == DW'(DIM - 1)) begin
                     c_ff <= '0;
                     if (mat_ff) begin
                        mat_ff <= 1'b0; row_ff <= '0; state_ff <= S_FACT;
                     end else mat_ff <= 1'b1;
                  end else c_ff <= c_ff + 1'b1;
               end
            end
            S_FACT: begin
               if (row_ff == col_ff) begin
                  if (row_ff == DW'(DIM - 1)) begin
                     if (col_ff == DW'(DIM - 1)) begin
                        cnt_ff <= '0; ph_ff <= 1'b0; state_ff <= S_OUT;
                     end else begin
                        col_ff <= col_ff + 1'b1; row_ff <= col_ff + 1'b1;
                        best_ff <= col_ff + 1'b1; state_ff <= S_SRCH;
                     end
                  end else row_ff <= row_ff + 1'b1;
               end else begin
                  fact_ff <= work_ff[NW'(row_ff) * NW'(DIM) + NW'(col_ff)];
                  c_ff <= '0; mat_ff <= 1'b0; ph_ff <= 1'b0; state_ff <= S_ELIM;
               end
            end
            S_ELIM: begin
               ph_ff <= !ph_ff;
               if (ph_ff) begin
                  if (mat_ff) inv_ff[tidx] <= alu_res; else work_ff[tidx] <= alu_res;
                  if (alu_sat) ovf_ff <= 1'b1;
                  if (c_ff == DW'(DIM - 1)) begin
                     c_ff <= '0;
                     if (mat_ff) begin
                        mat_ff <= 1'b0;
                        if (row_ff == DW'(DIM - 1)) begin
                           if (col_ff == DW'(DIM - 1)) begin
                              cnt_ff <= '0; ph_ff <= 1'b0; state_ff <= S_OUT;
                           end else begin
                              col_ff <= col_ff + 1'b1; row_ff <= col_ff + 1'b1;
                              best_ff <= col_ff + 1'b1; state_ff <= S_SRCH;
                           end
                        end else begin
                           row_ff <= row_ff + 1'b1; state_ff <= S_FACT;
                        end
                     end else mat_ff <= 1'b1;
                  end else c_ff <= c_ff + 1'b1;
               end
            end
            S_OUT: begin
               if (!ph_ff) ph_ff <= 1'b1;
               else if (rsp_ready) begin
                  ph_ff <= 1'b0;
                  if (cnt_ff == (NW+1)'(N - 1)) begin
                     cnt_ff <= '0; state_ff <= S_LOAD;
                  end else cnt_ff <= cnt_ff + 1'b1;
               end
            end
            default: state_ff <= S_LOAD;
         endcase
      end
   end

   `MI_ASSERT_IMPL(a_excl, clock, reset, rsp_valid, !req_ready)
   `MI_ASSERT_NEXT(a_last, clock, reset, rsp_valid && rsp_ready && rsp_last_out,
      req_ready)
   `MI_ASSERT_NEXT(a_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_element_out))
endmodule

// ===== tb/matrix_inverse_4x4_top_test.sv =====
// testbench for matrix_inverse_4x4_top: directed and random 4x4 matrices checked
// against a gauss-jordan predictor built into this file
// depends on mi4_pkg and the matrix_inverse_4x4_top design files
module matrix_inverse_4x4_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   typedef mi4_pkg::elem_type elem_type;

   localparam int N = 4;
   localparam int FRAC = 16;
   localparam int NEL = N * N;
   localparam longint MAX32 = 64'sd2147483647;
   localparam longint MIN32 = -64'sd2147483648;
   localparam int CYCLE_LIMIT = 400000;

   typedef struct {
      elem_type value;
      bit       singular;
      bit       overflow;
      bit       last;
   } inverse_elem_type;

   logic clock, reset;
   logic req_valid, req_ready;
   logic signed [31:0] req_element_in;
   logic rsp_valid, rsp_ready;
   logic signed [31:0] rsp_element_out;
   logic rsp_singular, rsp_overflow, rsp_last_out;
   logic csr_write_enable;
   logic [15:0] csr_pivot_epsilon;

   inverse_elem_type expected_inverse[$];
   elem_type loaded_matrix[NEL];
   int loaded_count = 0;
   int unsigned epsilon_model = 1;
   bit sat_flag;
   int error_count = 0;
   int cycle_count = 0;
   bit idle_on = 1;
   int hold_request = 0;

   matrix_inverse_4x4_top u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_element_in(req_element_in),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_element_out(rsp_element_out),
      .rsp_singular(rsp_singular), .rsp_overflow(rsp_overflow),
      .rsp_last_out(rsp_last_out),
      .csr_write_enable(csr_write_enable), .csr_pivot_epsilon(csr_pivot_epsilon)
   );

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   function automatic elem_type clamp32(input longint v);
      if (v > MAX32) begin
         sat_flag = 1;
         return elem_type'(MAX32);
      end
      if (v < MIN32) begin
         sat_flag = 1;
         return elem_type'(MIN32);
      end
      return elem_type'(v);
   endfunction

   function automatic longint qmul(input elem_type a, input elem_type b);
      longint p;
      p = longint'(a) * longint'(b);
      return (p + (longint'(1) << (FRAC - 1))) >>> FRAC;
   endfunction

   function automatic longint magnitude(input elem_type v);
      return v < 0 ? -longint'(v) : longint'(v);
   endfunction

   function automatic elem_type reciprocal(input elem_type p);
      longint m, q;
      m = magnitude(p);
      q = ((longint'(1) << (2 * FRAC)) + m / 2) / m;
      return clamp32(p < 0 ? -q : q);
   endfunction

   // gauss-jordan with partial pivoting, pushes the 16 expected result elements
   function automatic void predict_inverse();
      elem_type w[NEL], inv[NEL], t, rc, f;
      int best;
      bit sing;
      sing = 0;
      sat_flag = 0;
      for (int k = 0; k < NEL; k++) begin
         w[k] = loaded_matrix[k];
         inv[k] = (k / N == k % N) ? elem_type'(1 << FRAC) : '0;
      end
      for (int col = 0; col < N && !sing; col++) begin
         best = col;
         for (int r = col + 1; r < N; r++)
            if (magnitude(w[r*N+col]) > magnitude(w[best*N+col])) best = r;
         if (magnitude(w[best*N+col]) <= longint'(epsilon_model)) begin
            sing = 1;
         end else begin
            for (int c = 0; c < N; c++) begin
               t = w[col*N+c]; w[col*N+c] = w[best*N+c]; w[best*N+c] = t;
               t = inv[col*N+c]; inv[col*N+c] = inv[best*N+c]; inv[best*N+c] = t;
            end
            rc = reciprocal(w[col*N+col]);
            for (int c = 0; c < N; c++) begin
               w[col*N+c] = clamp32(qmul(w[col*N+c], rc));
               inv[col*N+c] = clamp32(qmul(inv[col*N+c], rc));
            end
            for (int r = 0; r < N; r++) begin
               if (r != col) begin
                  f = w[r*N+col];
                  for (int c = 0; c < N; c++) begin
                     w[r*N+c] = clamp32(longint'(w[r*N+c]) - qmul(w[col*N+c], f));
                     inv[r*N+c] = clamp32(longint'(inv[r*N+c]) - qmul(inv[col*N+c], f));
                  end
               end
            end
         end
      end
      for (int k = 0; k < NEL; k++)
         expected_inverse.push_back('{sing ? loaded_matrix[k] : inv[k], sing, sat_flag,
                                      k == NEL - 1});
   endfunction

   task automatic send_element(input elem_type e);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_valid <= 1;
      req_element_in <= e;
      do @(posedge clock); while (!req_ready);
      loaded_matrix[loaded_count] = e;
      loaded_count++;
      if (loaded_count == NEL) begin
         loaded_count = 0;
         predict_inverse();
      end
   endtask

   task automatic send_matrix(input elem_type m[NEL]);
      for (int k = 0; k < NEL; k++) send_element(m[k]);
   endtask

   task automatic drain();
      req_valid <= 0;
      @(posedge clock);
      while (expected_inverse.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic set_epsilon(input int unsigned v);
      drain();
      csr_write_enable <= 1;
      csr_pivot_epsilon <= v[15:0];
      @(posedge clock);
      csr_write_enable <= 0;
      epsilon_model = v & 16'hffff;
   endtask

   function automatic elem_type rand_elem(input int unsigned span);
      return elem_type'($signed($urandom_range(0, 2 * span)) - $signed(span));
   endfunction

   // kind 0..5 well conditioned, 6 full range, 7 repeated row, 8 near epsilon
   task automatic send_random_matrix();
      elem_type m[NEL];
      int kind, src_row, dst_row;
      kind = $urandom_range(0, 8);
      for (int k = 0; k < NEL; k++) begin
         case (kind)
            6: m[k] = elem_type'($urandom);
            8: m[k] = rand_elem(epsilon_model + 3);
            default: begin
               if (k / N == k % N)
                  m[k] = elem_type'($urandom_range(1 << 16, 1 << 20))
                         * (($urandom_range(0, 1) == 1) ? -1 : 1);
               else
                  m[k] = rand_elem(1 << 16);
            end
         endcase
      end
      if (kind == 7) begin
         src_row = $urandom_range(0, N - 1);
         dst_row = (src_row + $urandom_range(1, N - 1)) % N;
         for (int c = 0; c < N; c++) m[dst_row*N+c] = m[src_row*N+c];
      end
      send_matrix(m);
   endtask

   task automatic test_identity_and_extremes();
      elem_type m[NEL];
      for (int k = 0; k < NEL; k++) m[k] = (k / N == k % N) ? elem_type'(1 << FRAC) : '0;
      send_matrix(m);
      for (int k = 0; k < NEL; k++) m[k] = '0;
      m[0] = elem_type'(MIN32); m[5] = elem_type'(MAX32);
      m[10] = elem_type'(MIN32); m[15] = elem_type'(1);
      m[1] = elem_type'(MAX32); m[14] = elem_type'(MIN32);
      send_matrix(m);
   endtask

   task automatic test_pivot_swaps();
      elem_type m[NEL];
      for (int k = 0; k < NEL; k++) m[k] = '0;
      // ties in column zero, permutation elsewhere
      m[0*N+0] = elem_type'(2 << FRAC); m[1*N+0] = elem_type'(-(2 << FRAC));
      m[0*N+3] = elem_type'(1 << FRAC); m[1*N+1] = elem_type'(3 << FRAC);
      m[2*N+0] = elem_type'(2 << FRAC); m[2*N+2] = elem_type'(1 << 14);
      m[3*N+1] = elem_type'(5 << FRAC); m[3*N+3] = elem_type'(-(7 << 12));
      send_matrix(m);
   endtask

   task automatic test_singular();
      elem_type m[NEL];
      for (int k = 0; k < NEL; k++) m[k] = '0;
      send_matrix(m);
      for (int k = 0; k < NEL; k++) m[k] = rand_elem(1 << 20);
      for (int c = 0; c < N; c++) m[3*N+c] = m[1*N+c];
      send_matrix(m);
   endtask

   task automatic test_backpressure();
      hold_request = 2500;
      send_random_matrix();
      send_random_matrix();
   endtask

   task automatic test_random(input int count);
      for (int i = 0; i < count; i++) send_random_matrix();
   endtask

   initial begin
      reset <= 1;
      req_valid <= 0;
      req_element_in <= '0;
      csr_write_enable <= 0;
      csr_pivot_epsilon <= '0;
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      test_identity_and_extremes();
      test_pivot_swaps();
      test_singular();
      set_epsilon(0);
      test_identity_and_extremes();
      test_backpressure();
      set_epsilon(16'hffff);
      test_singular();
      test_random(1);
      set_epsilon($urandom_range(0, 65535));
      test_random(1);
      set_epsilon(1);
      idle_on = 0;
      test_random(1);
      drain();
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      rsp_ready <= 0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_request > 0) begin
            rsp_ready <= 0;
            repeat (hold_request) @(posedge clock);
            hold_request = 0;
         end else if (idle_on && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 0;
            repeat ($urandom_range(1, 7)) @(posedge clock);
         end
         rsp_ready <= 1;
      end
   end

   // checks every result transaction against the oldest prediction
   always @(posedge clock) begin
      inverse_elem_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_inverse.size() == 0) begin
            $error("unexpected result transaction, element_out %0d", rsp_element_out);
            error_count++;
         end else begin
            e = expected_inverse.pop_front();
            if (rsp_element_out !== e.value) begin
               $error("element_out expected %0d actual %0d", e.value, rsp_element_out);
               error_count++;
            end
            if (rsp_singular !== e.singular) begin
               $error("singular expected %0d actual %0d", e.singular, rsp_singular);
               error_count++;
            end
            if (rsp_overflow !== e.overflow) begin
               $error("overflow expected %0d actual %0d", e.overflow, rsp_overflow);
               error_count++;
            end
            if (rsp_last_out !== e.last) begin
               $error("last_out expected %0d actual %0d", e.last, rsp_last_out);
               error_count++;
            end
         end
      end
   end
endmodule

// ===== filelist.f =====
+incdir+design
design/mi4_pkg.sv
design/mi4_alu.sv
design/mi4_recip.sv
design/matrix_inverse_4x4_top.sv
tb/matrix_inverse_4x4_top_test.sv
